FILE: src/bpt_pkg.sv
// Shared types and constants for the byte packetizer trigger block.
package bpt_pkg;

  localparam int unsigned MAX_DELIM = 8;

  localparam logic [15:0] PAYLOAD_LIMIT = 16'hFFEF;
  localparam logic [23:0] IDLE_MAX      = 24'hFFFFFF;

  // Request kinds carried on in_tuser
  localparam logic [1:0] CMD_DATA  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  // Completion causes
  localparam logic [1:0] CAUSE_NONE  = 2'd0;
  localparam logic [1:0] CAUSE_SIZE  = 2'd1;
  localparam logic [1:0] CAUSE_IDLE  = 2'd2;
  localparam logic [1:0] CAUSE_DELIM = 2'd3;

  // Register indexes (byte address is 8 * index)
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd0;
  localparam logic [1:0] REG_QUIET_TICKS = 2'd1;
  localparam logic [1:0] REG_DELIM_LEN   = 2'd2;
  localparam logic [1:0] REG_DELIM_BYTES = 2'd3;

  localparam int unsigned OUT_W = 40;

  // Result request as packed on out_tdata, lowest field last
  typedef struct packed {
    logic [2:0]  pad;
    logic        overflow;
    logic [15:0] payload_length;
    logic [15:0] byte_index;
    logic        byte_accepted;
    logic [1:0]  ready_cause;
    logic        ready_res;
  } result_t;

endpackage

FILE: src/byte_packetizer_triggers.sv
// Packet completion detector for a serial byte stream: top level.
// Takes requests (data byte, tick or start-new-packet) and gives one registered
// result per request in the cycle after acceptance. State update and completion
// check are a single compare-and-increment pass, so in_tready stays high whenever
// the output register is empty or is being emptied in the same cycle; the rate is one
// request per cycle while out_tready is high. The user must write registers over the
// APB-style port only while the stream is idle (not enforced by the block); every write restarts the packet.
module byte_packetizer_triggers (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] ready_res, [2:1] ready_cause, [3] byte_accepted, [19:4] byte_index,
  // [35:20] payload_length, [36] overflow, [39:37] zero
  output logic [39:0] out_tdata,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import bpt_pkg::*;

  // configuration registers
  logic [15:0] max_payload_r;
  logic [23:0] quiet_ticks_r;
  logic [3:0]  delim_len_r;
  logic [63:0] delim_bytes_r;

  // packet state
  logic [15:0] count_r, count_nxt;
  logic [3:0]  match_r, match_nxt;
  logic [23:0] idle_r,  idle_nxt;

  logic        out_valid_r;
  result_t     res_r, res_nxt;

  logic        in_fire;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;
  logic [15:0] limit;
  logic [3:0]  dlen;
  logic        full;
  logic [7:0]  want;
  logic [1:0]  cause;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:3];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    unique case (cfg_idx)
      REG_MAX_PAYLOAD: cfg_prdata = {48'd0, max_payload_r};
      REG_QUIET_TICKS: cfg_prdata = {40'd0, quiet_ticks_r};
      REG_DELIM_LEN:   cfg_prdata = {60'd0, delim_len_r};
      REG_DELIM_BYTES: cfg_prdata = delim_bytes_r;
      default:         cfg_prdata = 64'd0;
    endcase
  end

  assign in_tready  = ~out_valid_r | out_tready;
  assign in_fire    = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

  // effective limits: zero payload acts as one, oversize values clamp
  always_comb begin
    if (max_payload_r == 16'd0) begin
      limit = 16'd1;
    end else if (max_payload_r > PAYLOAD_LIMIT) begin
      limit = PAYLOAD_LIMIT;
    end else begin
      limit = max_payload_r;
    end
    dlen = (delim_len_r > 4'(MAX_DELIM)) ? 4'(MAX_DELIM) : delim_len_r;
  end

  assign full = (count_r >= limit);
  assign want = delim_bytes_r[{match_r[2:0], 3'b000} +: 8];

  always_comb begin
    count_nxt = count_r;
    match_nxt = match_r;
    idle_nxt  = idle_r;
    res_nxt   = '0;
    unique case (in_tuser)
      CMD_DATA: begin
        if (full) begin
          res_nxt.overflow = 1'b1;
        end else begin
          res_nxt.byte_accepted = 1'b1;
          res_nxt.byte_index    = count_r;
          count_nxt             = count_r + 16'd1;
          idle_nxt              = '0;
          // naive match: a mismatch drops back to zero without a recheck
          if (dlen != 4'd0 && match_r < dlen) begin
            match_nxt = (want == in_tdata) ? match_r + 4'd1 : 4'd0;
          end
        end
      end
      CMD_TICK: begin
        if (idle_r != IDLE_MAX) begin
          idle_nxt = idle_r + 24'd1;
        end
      end
      CMD_START: begin
        count_nxt = '0;
        match_nxt = '0;
        idle_nxt  = '0;
      end
      default: ;
    endcase

    cause = CAUSE_NONE;
    if (count_nxt != 16'd0) begin
      priority if (count_nxt >= limit) begin
        cause = CAUSE_SIZE;
      end else if (quiet_ticks_r != 24'd0 && idle_nxt >= quiet_ticks_r) begin
        cause = CAUSE_IDLE;
      end else if (dlen != 4'd0 && match_nxt >= dlen) begin
        cause = CAUSE_DELIM;
      end
    end
    res_nxt.ready_cause    = cause;
    res_nxt.ready_res      = (cause != CAUSE_NONE);
    res_nxt.payload_length = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= 16'd1;
      quiet_ticks_r <= '0;
      delim_len_r   <= '0;
      delim_bytes_r <= '0;
      count_r       <= '0;
      match_r       <= '0;
      idle_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_MAX_PAYLOAD: max_payload_r <= cfg_pwdata[15:0];
          REG_QUIET_TICKS: quiet_ticks_r <= cfg_pwdata[23:0];
          REG_DELIM_LEN:   delim_len_r   <= cfg_pwdata[3:0];
          REG_DELIM_BYTES: delim_bytes_r <= cfg_pwdata;
          default: ;
        endcase
        count_r <= '0;
        match_r <= '0;
        idle_r  <= '0;
      end else if (in_fire) begin
        count_r <= count_nxt;
        match_r <= match_nxt;
        idle_r  <= idle_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

endmodule

FILE: src/bpt_checker.sv
// Port-level checker for the byte packetizer trigger block, with its bind.
module bpt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);
  import bpt_pkg::*;

  result_t res;
  assign res = out_tdata;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res.ready_res == (res.ready_cause != CAUSE_NONE)))
    else $error("ready flag disagrees with cause");

  a_acc_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(res.byte_accepted && res.overflow))
    else $error("byte both stored and dropped");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.overflow |-> res.ready_cause == CAUSE_SIZE)
    else $error("overflow without size-limit completion");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.payload_length == 16'd0 |-> !res.ready_res)
    else $error("empty packet reported complete");

endmodule

bind byte_packetizer_triggers bpt_checker u_bpt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: bench/packet_status_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the byte packetizer trigger block: predicts each packet status and compares.
module packet_status_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  input  logic        out_tvalid,
  input  logic        out_tready,
  // [0] ready_res, [2:1] ready_cause, [3] byte_accepted, [19:4] byte_index,
  // [35:20] payload_length, [36] overflow, [39:37] zero
  input  logic [39:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          pending,
  output int          fail_count,
  output int          checked,
  output int          size_hits,
  output int          idle_hits,
  output int          delim_hits,
  output int          drop_hits
);
  import bpt_pkg::*;

  // register copies
  logic [15:0] max_pl;
  logic [23:0] quiet;
  logic [3:0]  dlen;
  logic [63:0] delim;

  // packet state
  logic [15:0] count;
  logic [3:0]  match;
  logic [23:0] idle;

  result_t status_due[$];

  task automatic restart_packet();
    count = '0;
    match = '0;
    idle  = '0;
  endtask

  task automatic advance_packet(input logic [1:0] cmd, input logic [7:0] b,
                                output result_t r);
    logic [15:0] lim;
    logic [3:0]  dl;
    lim = (max_pl == 16'd0) ? 16'd1 : (max_pl > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : max_pl;
    dl  = (dlen > MAX_DELIM) ? MAX_DELIM[3:0] : dlen;
    r   = '0;
    case (cmd)
      CMD_DATA: begin
        if (count >= lim) begin
          r.overflow = 1'b1;
        end else begin
          r.byte_accepted = 1'b1;
          r.byte_index    = count;
          count = count + 16'd1;
          idle  = '0;
          // naive matcher: a mismatching byte is not retried as a fresh start
          if (dl != 4'd0 && match < dl)
            match = (delim[8*match +: 8] == b) ? match + 4'd1 : 4'd0;
        end
      end
      CMD_TICK: begin
        if (idle != IDLE_MAX) idle = idle + 24'd1;
      end
      CMD_START: restart_packet();
      default: ;
    endcase
    r.ready_cause = CAUSE_NONE;
    if (count != 16'd0) begin
      if (count >= lim) r.ready_cause = CAUSE_SIZE;
      else if (quiet != 24'd0 && idle >= quiet) r.ready_cause = CAUSE_IDLE;
      else if (dl != 4'd0 && match >= dl) r.ready_cause = CAUSE_DELIM;
    end
    r.ready_res      = (r.ready_cause != CAUSE_NONE);
    r.payload_length = count;
  endtask

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    logic    bad;
    if (!rst_n) begin
      max_pl = 16'd1;
      quiet  = '0;
      dlen   = '0;
      delim  = '0;
      restart_packet();
      status_due.delete();
      fail_count = 0;
      checked    = 0;
      size_hits  = 0;
      idle_hits  = 0;
      delim_hits = 0;
      drop_hits  = 0;
    end else begin
      // results are registered, so a status never leaves in its request's own cycle; retire before predicting
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata);
        checked++;
        if (status_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] status with no request outstanding: %h", $time, out_tdata);
        end else begin
          want = status_due.pop_front();
          bad = (got.ready_res      !== want.ready_res)      ||
                (got.ready_cause    !== want.ready_cause)    ||
                (got.byte_accepted  !== want.byte_accepted)  ||
                (got.byte_index     !== want.byte_index)     ||
                (got.payload_length !== want.payload_length) ||
                (got.overflow       !== want.overflow)       ||
                (got.pad            !== want.pad);
          if (bad) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("[%0t] status differs: exp rdy=%0d cause=%0d acc=%0d idx=%0d len=%0d ovf=%0d pad=%0d",
                       $time, want.ready_res, want.ready_cause, want.byte_accepted,
                       want.byte_index, want.payload_length, want.overflow, want.pad);
              $display("[%0t]                 got rdy=%0d cause=%0d acc=%0d idx=%0d len=%0d ovf=%0d pad=%0d",
                       $time, got.ready_res, got.ready_cause, got.byte_accepted,
                       got.byte_index, got.payload_length, got.overflow, got.pad);
            end
          end
          case (want.ready_cause)
            CAUSE_SIZE:  size_hits++;
            CAUSE_IDLE:  idle_hits++;
            CAUSE_DELIM: delim_hits++;
            default: ;
          endcase
          if (want.overflow) drop_hits++;
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:3])
          REG_MAX_PAYLOAD: max_pl = cfg_pwdata[15:0];
          REG_QUIET_TICKS: quiet  = cfg_pwdata[23:0];
          REG_DELIM_LEN:   dlen   = cfg_pwdata[3:0];
          REG_DELIM_BYTES: delim  = cfg_pwdata;
          default: ;
        endcase
        restart_packet();
      end
      if (in_tvalid && in_tready) begin
        advance_packet(in_tuser, in_tdata, want);
        status_due.push_back(want);
      end
    end
    pending = status_due.size();
  end

endmodule

FILE: bench/tb_byte_packetizer_triggers.sv
`timescale 1ns / 100ps
// Testbench top for the byte packetizer trigger block: clock, reset, stimulus and verdict.
module tb_byte_packetizer_triggers;
  import bpt_pkg::*;

  localparam int         REQ_TARGET  = 1050;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         HOLD_CYCLES = 250;
  localparam logic [1:0] CMD_SPARE   = 2'd3;  // unused code, block reports status only

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic [1:0]  in_tuser;   // [1:0] cmd
  logic        out_tvalid;
  logic        out_tready;
  // [0] ready_res, [2:1] ready_cause, [3] byte_accepted, [19:4] byte_index,
  // [35:20] payload_length, [36] overflow, [39:37] zero
  logic [39:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  int pending, fail_count, checked, size_hits, idle_hits, delim_hits, drop_hits;
  int sent = 0;
  int cycles = 0;
  bit calm = 1'b0;

  // stimulus-side copies used only to shape the request stream
  logic [23:0] cur_quiet;
  logic [3:0]  cur_dlen;
  logic [63:0] cur_delim;

  byte_packetizer_triggers u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  packet_status_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .pending     (pending),
    .fail_count  (fail_count),
    .checked     (checked),
    .size_hits   (size_hits),
    .idle_hits   (idle_hits),
    .delim_hits  (delim_hits),
    .drop_hits   (drop_hits)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d statuses outstanding", cycles, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int draw_gap();
    if (calm) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 13));
  endfunction

  task automatic send_req(input logic [1:0] cmd, input logic [7:0] b);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    if (cmd != CMD_SPARE) sent++;
  endtask

  // stop offering and wait for every outstanding status
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_QUIET_TICKS: cur_quiet = value[23:0];
      REG_DELIM_LEN:   cur_dlen  = value[3:0];
      REG_DELIM_BYTES: cur_delim = value;
      default: ;
    endcase
  endtask

  // result side: per-request stall, plus two long hold-offs to back up the input
  initial begin : sink
    int got_n;
    int stall;
    got_n = 0;
    wait (rst_n);
    forever begin
      stall = (got_n == 200 || got_n == 650) ? HOLD_CYCLES : draw_gap();
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got_n++;
    end
  end

  initial begin : source
    int          pick;
    int          k;
    int          bad;
    int          dl_eff;
    int          stop_at;
    logic [7:0]  b;
    logic [63:0] v;
    bit          first;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = CMD_DATA;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    cur_quiet   = '0;
    cur_dlen    = '0;
    cur_delim   = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // defaults: one-byte packets, no idle or delimiter trigger
    send_req(CMD_TICK, 8'h00);    // tick on an empty packet
    send_req(CMD_SPARE, 8'hFF);
    send_req(CMD_DATA, 8'h00);
    send_req(CMD_DATA, 8'hFF);    // packet full, dropped
    send_req(CMD_START, 8'hFF);
    send_req(CMD_DATA, 8'hFF);
    send_req(CMD_START, 8'h00);

    settle();
    cfg_write(REG_MAX_PAYLOAD, 64'd0);   // zero behaves as one
    send_req(CMD_DATA, 8'h5A);
    send_req(CMD_DATA, 8'hA5);

    settle();
    cfg_write(REG_MAX_PAYLOAD, 64'd8);
    cfg_write(REG_QUIET_TICKS, 64'd3);
    cfg_write(REG_DELIM_BYTES, 64'h0123_4567_89AB_AA55);
    cfg_write(REG_DELIM_LEN, 64'd2);
    send_req(CMD_DATA, 8'h55);
    send_req(CMD_DATA, 8'h55);    // mismatch, not retried as a new start
    send_req(CMD_DATA, 8'hAA);
    send_req(CMD_DATA, 8'h55);
    send_req(CMD_DATA, 8'hAA);    // delimiter complete
    send_req(CMD_DATA, 8'h00);    // match index holds
    repeat (3) send_req(CMD_TICK, 8'h00);   // idle wins over delimiter
    send_req(CMD_DATA, 8'h77);
    send_req(CMD_DATA, 8'h88);    // size wins over everything
    send_req(CMD_DATA, 8'h99);

    first = 1'b1;
    while (sent < REQ_TARGET) begin
      settle();
      if (first || $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0:       v = 64'd0;
          1:       v = 64'd1;
          2:       v = 64'(PAYLOAD_LIMIT);
          3:       v = 64'hFFF0;
          4:       v = 64'hFFFF;
          default: v = 64'($urandom_range(2, 24));
        endcase
        cfg_write(REG_MAX_PAYLOAD, v);
      end
      if (first || $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0:       v = 64'd0;
          1:       v = 64'(IDLE_MAX);
          2:       v = 64'($urandom_range(0, 24'hFFFFFF));
          default: v = 64'($urandom_range(1, 6));
        endcase
        cfg_write(REG_QUIET_TICKS, v);
      end
      if (first || $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0:       v = 64'($urandom_range(9, 15));
          1:       v = 64'd0;
          default: v = 64'($urandom_range(1, 8));
        endcase
        cfg_write(REG_DELIM_LEN, v);
      end
      if (first || $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 7))
          0:       v = 64'd0;
          1:       v = '1;
          2:       v = {8{8'($urandom_range(0, 255))}};
          default: v = {$urandom, $urandom};
        endcase
        cfg_write(REG_DELIM_BYTES, v);
      end
      first   = 1'b0;
      calm    = ($urandom_range(0, 3) == 0);
      dl_eff  = (cur_dlen > MAX_DELIM) ? MAX_DELIM : cur_dlen;
      stop_at = sent + $urandom_range(30, 110);
      while (sent < stop_at) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          send_req(CMD_START, 8'($urandom_range(0, 255)));
        end else if (pick < 11) begin
          send_req(CMD_SPARE, 8'($urandom_range(0, 255)));
        end else if (pick < 30) begin
          // burst of ticks, sometimes long enough to reach a short quiet threshold
          k = (cur_quiet != 0 && cur_quiet <= 8) ? $urandom_range(1, cur_quiet + 1)
                                                 : $urandom_range(1, 3);
          repeat (k) send_req(CMD_TICK, 8'($urandom_range(0, 255)));
        end else if (pick < 45 && dl_eff != 0) begin
          // whole delimiter, sometimes with one byte corrupted
          bad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, dl_eff - 1) : dl_eff;
          for (int j = 0; j < dl_eff; j++) begin
            b = cur_delim[8*j +: 8];
            if (j == bad) b = b ^ (8'd1 << $urandom_range(0, 7));
            send_req(CMD_DATA, b);
          end
        end else begin
          b = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                   : cur_delim[8*$urandom_range(0, 7) +: 8];
          send_req(CMD_DATA, b);
        end
      end
    end

    calm = 1'b0;
    settle();
    repeat (10) @(negedge clk);
    $display("run covered %0d requests and %0d checked statuses", sent, checked);
    $display("completions: size %0d, idle %0d, delimiter %0d; dropped bytes %0d",
             size_hits, idle_hits, delim_hits, drop_hits);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
